// ----- hdl/odf_pkg.sv -----
// Shared definitions for the obstacle-avoidance drive mode machine.
// Mode codes, configuration register indexes, reset values, speed constants
// and the structs passed between the top level and odf_core. No dependencies.
package odf_pkg;

    // Default widths handed to the top-level parameters
    localparam int ODF_TIME_BITS = 32;
    localparam int ODF_DIST_BITS = 8;

    localparam int MODE_W  = 6;
    localparam int SPEED_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Mode codes: even = entering an action, odd = action in progress
    localparam logic [MODE_W-1:0] MODE_WAIT_GO    = 6'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT_RUN   = 6'd1;
    localparam logic [MODE_W-1:0] MODE_FWD_GO     = 6'd2;
    localparam logic [MODE_W-1:0] MODE_TURN_R_GO  = 6'd4;
    localparam logic [MODE_W-1:0] MODE_TURN_L_GO  = 6'd6;
    localparam logic [MODE_W-1:0] MODE_PIV_R_GO   = 6'd8;
    localparam logic [MODE_W-1:0] MODE_PIV_L_GO   = 6'd10;
    localparam logic [MODE_W-1:0] MODE_BACK_R_GO  = 6'd16;
    localparam logic [MODE_W-1:0] MODE_BACK_L_GO  = 6'd18;
    localparam logic [MODE_W-1:0] MODE_VEER_R_GO  = 6'd24;
    localparam logic [MODE_W-1:0] MODE_VEER_L_GO  = 6'd26;
    localparam logic [MODE_W-1:0] MODE_HARD_R_GO  = 6'd28;
    localparam logic [MODE_W-1:0] MODE_HARD_L_GO  = 6'd30;
    localparam logic [MODE_W-1:0] MODE_UTURN_GO   = 6'd32;
    localparam logic [MODE_W-1:0] MODE_UTURN_RUN  = 6'd33;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_STOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_BACK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TURN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CLEAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_NEAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UTURN_TIME  = 3'd6;

    // Configuration reset values
    localparam logic [7:0]  RST_CENTER_STOP = 8'd15;
    localparam logic [7:0]  RST_SIDE_BACK   = 8'd25;
    localparam logic [7:0]  RST_SIDE_TURN   = 8'd30;
    localparam logic [7:0]  RST_SIDE_CLEAR  = 8'd20;
    localparam logic [7:0]  RST_CENTER_NEAR = 8'd35;
    localparam logic [15:0] RST_START_DELAY = 16'd1000;
    localparam logic [15:0] RST_UTURN_TIME  = 16'd500;

    // Speed set-points in percent
    localparam logic signed [SPEED_W-1:0] SPD_ZERO   = 8'sd0;
    localparam logic signed [SPEED_W-1:0] SPD_CRUISE = 8'sd25;
    localparam logic signed [SPEED_W-1:0] SPD_SLOW   = 8'sd15;
    localparam logic signed [SPEED_W-1:0] SPD_VEER   = 8'sd12;
    localparam logic signed [SPEED_W-1:0] SPD_PIVOT  = -8'sd15;
    localparam logic signed [SPEED_W-1:0] SPD_BACK   = -8'sd30;

    typedef struct packed {
        logic [7:0]  center_stop;
        logic [7:0]  side_back;
        logic [7:0]  side_turn;
        logic [7:0]  side_clear;
        logic [7:0]  center_near;
        logic [15:0] start_delay;
        logic [15:0] uturn_time;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
    } res_t;

endpackage

// ----- hdl/odf_core.sv -----
// Mode machine state and next-state logic for the drive controller.
// Holds mode, time counter, U-turn start mark and set-points; uses odf_pkg.
module odf_core
    import odf_pkg::*;
#(
    parameter int TIME_BITS = ODF_TIME_BITS,
    parameter int DIST_BITS = ODF_DIST_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 action,
    input  logic [DIST_BITS-1:0] dist_center,
    input  logic [DIST_BITS-1:0] dist_left,
    input  logic [DIST_BITS-1:0] dist_right,
    input  logic [DIST_BITS-1:0] dist_left_outer,
    input  logic [DIST_BITS-1:0] dist_right_outer,
    input  cfg_t                 cfg,
    output res_t                 res_next
);

    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [TIME_BITS-1:0]      elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]      start_reg, start_next;
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic signed [SPEED_W-1:0] left_reg, left_next;

    logic [DIST_BITS-1:0] thr_stop, thr_back, thr_turn, thr_clr, thr_near;
    logic [MODE_W-1:0]    choice;
    logic [TIME_BITS-1:0] uturn_age;

    assign thr_stop = DIST_BITS'(cfg.center_stop);
    assign thr_back = DIST_BITS'(cfg.side_back);
    assign thr_turn = DIST_BITS'(cfg.side_turn);
    assign thr_clr  = DIST_BITS'(cfg.side_clear);
    assign thr_near = DIST_BITS'(cfg.center_near);

    assign uturn_age = elapsed_reg - start_reg;

    // Prioritized obstacle rule
    always_comb begin
        if (dist_center < thr_stop) begin
            choice = MODE_UTURN_GO;
        end else if (dist_left < thr_back) begin
            choice = MODE_BACK_L_GO;
        end else if (dist_right < thr_back) begin
            choice = MODE_BACK_R_GO;
        end else if (dist_right < thr_turn && dist_left > thr_clr && dist_center > thr_clr) begin
            choice = MODE_TURN_R_GO;
        end else if (dist_left < thr_turn && dist_right > thr_clr && dist_center > thr_clr) begin
            choice = MODE_TURN_L_GO;
        end else if (dist_center < thr_near && dist_right > thr_clr && dist_left > thr_clr) begin
            choice = (dist_right > dist_left) ? MODE_HARD_R_GO : MODE_HARD_L_GO;
        end else if (dist_left_outer > thr_turn && dist_right_outer < thr_near) begin
            choice = MODE_VEER_R_GO;
        end else if (dist_right_outer > thr_turn && dist_left_outer < thr_near) begin
            choice = MODE_VEER_L_GO;
        end else if (dist_center < thr_near) begin
            choice = (dist_right > dist_left) ? MODE_PIV_L_GO : MODE_PIV_R_GO;
        end else begin
            choice = MODE_FWD_GO;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        start_next   = start_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        if (!action) begin
            elapsed_next = elapsed_reg + 1'b1;
        end else begin
            case (mode_reg)
                MODE_WAIT_GO: begin
                    // Counter restarts at zero, so the delay test cannot pass here
                    elapsed_next = '0;
                    right_next   = SPD_ZERO;
                    left_next    = SPD_ZERO;
                    mode_next    = MODE_WAIT_RUN;
                end
                MODE_WAIT_RUN: begin
                    if (elapsed_reg > TIME_BITS'(cfg.start_delay)) begin
                        mode_next = MODE_FWD_GO;
                    end
                end
                MODE_FWD_GO: begin
                    right_next = SPD_CRUISE; left_next = SPD_CRUISE;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_TURN_R_GO: begin
                    right_next = SPD_CRUISE; left_next = SPD_SLOW;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_TURN_L_GO: begin
                    right_next = SPD_SLOW; left_next = SPD_CRUISE;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_PIV_R_GO: begin
                    right_next = SPD_SLOW; left_next = SPD_PIVOT;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_PIV_L_GO: begin
                    right_next = SPD_PIVOT; left_next = SPD_SLOW;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_BACK_R_GO: begin
                    right_next = SPD_ZERO; left_next = SPD_BACK;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_BACK_L_GO: begin
                    right_next = SPD_BACK; left_next = SPD_ZERO;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_VEER_R_GO: begin
                    right_next = SPD_CRUISE; left_next = SPD_VEER;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_VEER_L_GO: begin
                    right_next = SPD_VEER; left_next = SPD_CRUISE;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_HARD_R_GO: begin
                    right_next = SPD_CRUISE; left_next = SPD_ZERO;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_HARD_L_GO: begin
                    right_next = SPD_ZERO; left_next = SPD_CRUISE;
                    mode_next  = mode_reg | 6'd1;
                end
                MODE_UTURN_GO: begin
                    right_next = SPD_SLOW; left_next = SPD_PIVOT;
                    start_next = elapsed_reg;
                    mode_next  = MODE_UTURN_RUN;
                end
                MODE_UTURN_RUN: begin
                    if (uturn_age > TIME_BITS'(cfg.uturn_time)) begin
                        mode_next = MODE_FWD_GO;
                    end
                end
                default: begin
                    // Odd modes below the U-turn re-run the rule; all else waits again
                    if (mode_reg[0] && mode_reg < MODE_UTURN_RUN) begin
                        if (choice != {mode_reg[MODE_W-1:1], 1'b0}) begin
                            mode_next = choice;
                        end
                    end else begin
                        mode_next = MODE_WAIT_GO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_WAIT_GO;
            elapsed_reg <= '0;
            start_reg   <= '0;
            right_reg   <= SPD_ZERO;
            left_reg    <= SPD_ZERO;
        end else if (accept) begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            start_reg   <= start_next;
            right_reg   <= right_next;
            left_reg    <= left_next;
        end
    end

    assign res_next.mode        = mode_next;
    assign res_next.right_speed = right_next;
    assign res_next.left_speed  = left_next;

    a_tick_keeps_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !action |=> $stable(mode_reg) && $stable(right_reg))
        else $error("tick item changed mode or set-point");

    a_mode_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg <= MODE_UTURN_RUN)
        else $error("mode register left the defined code range");

    a_uturn_marks_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && action && mode_reg == MODE_UTURN_GO
        |=> mode_reg == MODE_UTURN_RUN && start_reg == $past(elapsed_reg))
        else $error("U-turn entry did not mark its start time");

endmodule

// ----- hdl/obstacle_avoid_drive_fsm.sv -----
// Top level of the two-wheel obstacle-avoidance drive mode machine.
// Holds the configuration registers and a two-entry result buffer around
// odf_core; uses odf_pkg.
//
// Use:
//   Input channel (s_*): one item per handshake. s_action = 0 is a time tick,
//   s_action = 1 runs one decision step on the five distance readings.
//   Result channel (m_*): exactly one item per input item, in order, giving
//   the mode after that item and both signed speed set-points.
//   Configuration channel (cfg_*): cfg_index selects a register, cfg_data
//   carries the value (8-bit thresholds take the low byte). Always ready.
//   Write it only while no item is in flight.
// Throughput: one item per cycle is sustained while m_ready stays high.
// Each result is registered in the output entry, or in the skid entry
// while the receiver stalls. The whole decision is one pass of
// compare-and-select logic between the state and result registers.
// Reset (aresetn low, synchronous): mode goes to waiting, time counter,
// U-turn mark and set-points clear, thresholds return to defaults, and the
// result buffer empties.
// Stall: while m_ready is low, one more item is taken into the skid entry;
// s_ready drops only when both result entries are full.
module obstacle_avoid_drive_fsm
    import odf_pkg::*;
#(
    parameter int TIME_BITS = ODF_TIME_BITS,
    parameter int DIST_BITS = ODF_DIST_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [DIST_BITS-1:0]         s_dist_center,
    input  logic [DIST_BITS-1:0]         s_dist_left,
    input  logic [DIST_BITS-1:0]         s_dist_right,
    input  logic [DIST_BITS-1:0]         s_dist_left_outer,
    input  logic [DIST_BITS-1:0]         s_dist_right_outer,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [MODE_W-1:0]            m_mode,
    output logic signed [SPEED_W-1:0]    m_right_speed,
    output logic signed [SPEED_W-1:0]    m_left_speed,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    cfg_t cfg_reg;
    res_t res_next;
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic s_accept, m_pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_pop     = out_valid_reg && m_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_stop <= RST_CENTER_STOP;
            cfg_reg.side_back   <= RST_SIDE_BACK;
            cfg_reg.side_turn   <= RST_SIDE_TURN;
            cfg_reg.side_clear  <= RST_SIDE_CLEAR;
            cfg_reg.center_near <= RST_CENTER_NEAR;
            cfg_reg.start_delay <= RST_START_DELAY;
            cfg_reg.uturn_time  <= RST_UTURN_TIME;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CENTER_STOP: cfg_reg.center_stop <= cfg_data[7:0];
                CFG_SIDE_BACK:   cfg_reg.side_back   <= cfg_data[7:0];
                CFG_SIDE_TURN:   cfg_reg.side_turn   <= cfg_data[7:0];
                CFG_SIDE_CLEAR:  cfg_reg.side_clear  <= cfg_data[7:0];
                CFG_CENTER_NEAR: cfg_reg.center_near <= cfg_data[7:0];
                CFG_START_DELAY: cfg_reg.start_delay <= cfg_data;
                CFG_UTURN_TIME:  cfg_reg.uturn_time  <= cfg_data;
                default: ;
            endcase
        end
    end

    odf_core #(
        .TIME_BITS (TIME_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (s_accept),
        .action           (s_action),
        .dist_center      (s_dist_center),
        .dist_left        (s_dist_left),
        .dist_right       (s_dist_right),
        .dist_left_outer  (s_dist_left_outer),
        .dist_right_outer (s_dist_right_outer),
        .cfg              (cfg_reg),
        .res_next         (res_next)
    );

    // Result buffer: output entry plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_pop) begin
                if (skid_valid_reg) begin
                    // advance the waiting item into the output entry
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else if (s_accept) begin
                    out_reg <= res_next;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (s_accept) begin
                if (!out_valid_reg) begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    // hold the new item aside while the receiver stalls
                    skid_reg       <= res_next;
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mode        = out_reg.mode;
    assign m_right_speed = out_reg.right_speed;
    assign m_left_speed  = out_reg.left_speed;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output entry empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && out_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("item accepted during stall was not kept in skid entry");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry changed while receiver stalled");

endmodule
